### design/sobl_pkg.sv
`default_nettype none

package sobl_pkg;

  // pipeline depth: two stages in the alpha front end, six in each colour lane
  localparam int unsigned FrontStages = 2;
  localparam int unsigned LaneStages  = 6;
  localparam int unsigned NumStages   = FrontStages + LaneStages;

  localparam logic [8:0] OpacityReset = 9'd256;
  localparam logic [7:0] FullAlpha    = 8'd255;
  localparam logic [7:0] HalfAlpha    = 8'd128;

  // how a pixel is composited, decided once in the front end
  typedef enum logic [2:0] {
    MODE_PASS  = 3'b001,
    MODE_COPY  = 3'b010,
    MODE_BLEND = 3'b100
  } mode_e;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

  typedef struct packed {
    mode_e      mode;
    logic [7:0] sa;   // effective source alpha
    logic [7:0] da2;  // attenuated destination alpha
  } ctl_t;

  // one restoring division step: does the shifted divisor fit
  function automatic logic div_fits(input logic [16:0] rem, input logic [7:0] dv,
                                    input logic [2:0] pos);
    logic [16:0] dd;
    dd = 17'(dv) << pos;
    return rem >= dd;
  endfunction

  // one restoring division step: remainder afterwards
  function automatic logic [16:0] div_rem(input logic [16:0] rem, input logic [7:0] dv,
                                          input logic [2:0] pos);
    logic [16:0] dd;
    dd = 17'(dv) << pos;
    return (rem >= dd) ? rem - dd : rem;
  endfunction

endpackage

`default_nettype wire

### design/sobl_front.sv
`default_nettype none

module sobl_front
  import sobl_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic [FrontStages-1:0] en_i,
  input  wire logic [8:0]             opacity_i,
  input  wire pix_t                   src_i,
  input  wire pix_t                   dst_i,
  output ctl_t                        ctl_o,
  output pix_t                        src_o,
  output pix_t                        dst_o
);

  // stage 0: opacity scaling of source alpha
  logic [15:0] sa_mul;
  logic [7:0]  sa0_q;
  logic        off0_q;
  pix_t        src0_q, dst0_q;

  assign sa_mul = 16'(src_i.a) * 16'(opacity_i[7:0]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      sa0_q  <= opacity_i[8] ? src_i.a : sa_mul[15:8];
      off0_q <= (opacity_i == '0);
      src0_q <= src_i;
      dst0_q <= dst_i;
    end
  end

  // stage 1: destination alpha attenuation, divide by 255 with rounding
  logic [15:0] att;
  logic [16:0] att_q255;
  mode_e       mode1;
  ctl_t        ctl1_q;
  pix_t        src1_q, dst1_q;

  assign att      = 16'(FullAlpha - sa0_q) * 16'(dst0_q.a) + 16'(HalfAlpha);
  // exact floor(x / 255) for x below 2^16 - 1
  assign att_q255 = 17'(att) + 17'(att[15:8]) + 17'd1;

  always_comb begin
    if (off0_q || sa0_q == '0) begin
      mode1 = MODE_PASS;
    end else if (sa0_q == FullAlpha || dst0_q.a == '0) begin
      mode1 = MODE_COPY;
    end else begin
      mode1 = MODE_BLEND;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      ctl1_q.mode <= mode1;
      ctl1_q.sa   <= sa0_q;
      ctl1_q.da2  <= att_q255[15:8];
      src1_q      <= src0_q;
      dst1_q      <= dst0_q;
    end
  end

  assign ctl_o = ctl1_q;
  assign src_o = src1_q;
  assign dst_o = dst1_q;

endmodule

`default_nettype wire

### design/sobl_lane.sv
`default_nettype none

module sobl_lane
  import sobl_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic [LaneStages-1:0] en_i,
  input  wire ctl_t                  ctl_i,
  input  wire logic [7:0]            src_i,
  input  wire logic [7:0]            dst_i,
  output logic [7:0]                 res_o
);

  // stage 0: new alpha and the two weighted products
  mode_e       mode0_q;
  logic [7:0]  s0_q, d0_q, na0_q;
  logic [15:0] pd_q, ps_q;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      mode0_q <= ctl_i.mode;
      s0_q    <= src_i;
      d0_q    <= dst_i;
      na0_q   <= 8'(9'(ctl_i.da2) + 9'(ctl_i.sa));
      pd_q    <= 16'(dst_i) * 16'(ctl_i.da2);
      ps_q    <= 16'(src_i) * 16'(ctl_i.sa);
    end
  end

  // stage 1: numerator with half divisor for rounding
  mode_e       mode1_q;
  logic [7:0]  s1_q, d1_q, na1_q;
  logic [16:0] num_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      mode1_q <= mode0_q;
      s1_q    <= s0_q;
      d1_q    <= d0_q;
      na1_q   <= na0_q;
      num_q   <= 17'(pd_q) + 17'(ps_q) + 17'(na0_q >> 1);
    end
  end

  // stages 2..5: restoring divide, two quotient bits per stage
  mode_e       mode_dq [3];
  logic [7:0]  s_dq [3];
  logic [7:0]  d_dq [3];
  logic [7:0]  na_dq [3];
  logic [16:0] rem_q [3];
  logic [7:0]  quo_q [3];
  logic [7:0]  res_q;

  for (genvar j = 0; j < 4; j++) begin : g_div
    localparam int unsigned Hi = 7 - 2 * j;
    localparam int unsigned Lo = 6 - 2 * j;

    logic [16:0] rem_in, rem_mid;
    logic [7:0]  quo_in, quo_out, na_in, s_in, d_in;
    mode_e       mode_in;

    if (j == 0) begin : g_first
      assign rem_in  = num_q;
      assign quo_in  = '0;
      assign na_in   = na1_q;
      assign s_in    = s1_q;
      assign d_in    = d1_q;
      assign mode_in = mode1_q;
    end else begin : g_next
      assign rem_in  = rem_q[j-1];
      assign quo_in  = quo_q[j-1];
      assign na_in   = na_dq[j-1];
      assign s_in    = s_dq[j-1];
      assign d_in    = d_dq[j-1];
      assign mode_in = mode_dq[j-1];
    end

    always_comb begin
      rem_mid     = div_rem(rem_in, na_in, 3'(Hi));
      quo_out     = quo_in;
      quo_out[Hi] = div_fits(rem_in, na_in, 3'(Hi));
      quo_out[Lo] = div_fits(rem_mid, na_in, 3'(Lo));
    end

    if (j < 3) begin : g_mid
      always_ff @(posedge clk_i) begin
        if (en_i[2+j]) begin
          rem_q[j]   <= div_rem(rem_mid, na_in, 3'(Lo));
          quo_q[j]   <= quo_out;
          na_dq[j]   <= na_in;
          s_dq[j]    <= s_in;
          d_dq[j]    <= d_in;
          mode_dq[j] <= mode_in;
        end
      end
    end else begin : g_last
      always_ff @(posedge clk_i) begin
        if (en_i[2+j]) begin
          case (mode_in)
            MODE_PASS: res_q <= d_in;
            MODE_COPY: res_q <= s_in;
            default:   res_q <= quo_out;
          endcase
        end
      end
    end
  end

  assign res_o = res_q;

endmodule

`default_nettype wire

### design/straight_alpha_over_blend_unit.sv
`default_nettype none

// straight-alpha "over" compositor, 8-bit rgba, one pixel pair per transaction
//
// input stream:  s_axis_* carries a source and a destination pixel; a transaction
//                completes when tvalid and tready are both high
// output stream: m_axis_* carries the composited pixel, one per input transaction,
//                in the same order
// config:        cfg_valid_i / cfg_data_i write the 9-bit opacity register; it is
//                always ready and should only be written while the block is idle
//
// pipeline: eight register stages. throughput: one pixel per clock while the
// receiver does not stall, set by the fully pipelined datapath (opacity multiply,
// alpha divide by 255, products, an 8-bit restoring divider at two quotient bits
// per stage)
//
// reset empties the pipeline and sets opacity to 256 (full rate)
// when the receiver stalls, the last stage holds its pixel; earlier stages keep
// filling any bubbles, so s_axis_tready only drops once every stage is occupied
module straight_alpha_over_blend_unit
  import sobl_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // configuration write channel
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [8:0]  cfg_data_i,      // opacity
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [7:0] src_red, [15:8] src_green, [23:16] src_blue, [31:24] src_alpha,
  // [39:32] dst_red, [47:40] dst_green, [55:48] dst_blue, [63:56] dst_alpha
  input  wire logic [63:0] s_axis_tdata,
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [7:0] out_red, [15:8] out_green, [23:16] out_blue, [31:24] out_alpha
  output logic [31:0]      m_axis_tdata
);

  // opacity register
  logic [8:0] opacity_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      opacity_q <= OpacityReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      opacity_q <= cfg_data_i;
    end
  end

  // pipeline control: per-stage valid, a stage loads when empty or draining
  logic [NumStages-1:0] valid_q, valid_d, en;

  always_comb begin
    en[NumStages-1] = !valid_q[NumStages-1] || m_axis_tready;
    for (int k = NumStages - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  always_comb begin
    valid_d[0] = en[0] ? s_axis_tvalid : valid_q[0];
    for (int k = 1; k < NumStages; k++) begin
      valid_d[k] = en[k] ? valid_q[k-1] : valid_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NumStages-1];

  // unpack the pixel pair
  pix_t src_in, dst_in;

  assign src_in = '{r: s_axis_tdata[7:0],   g: s_axis_tdata[15:8],
                    b: s_axis_tdata[23:16], a: s_axis_tdata[31:24]};
  assign dst_in = '{r: s_axis_tdata[39:32], g: s_axis_tdata[47:40],
                    b: s_axis_tdata[55:48], a: s_axis_tdata[63:56]};

  // front end: effective source alpha, attenuated destination alpha, mode
  ctl_t ctl;
  pix_t src_f, dst_f;

  sobl_front u_front (
    .clk_i     (clk_i),
    .en_i      (en[FrontStages-1:0]),
    .opacity_i (opacity_q),
    .src_i     (src_in),
    .dst_i     (dst_in),
    .ctl_o     (ctl),
    .src_o     (src_f),
    .dst_o     (dst_f)
  );

  // colour lanes, one divider each
  logic [7:0] res_r, res_g, res_b;

  sobl_lane u_lane_r (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:FrontStages]),
    .ctl_i (ctl),
    .src_i (src_f.r),
    .dst_i (dst_f.r),
    .res_o (res_r)
  );

  sobl_lane u_lane_g (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:FrontStages]),
    .ctl_i (ctl),
    .src_i (src_f.g),
    .dst_i (dst_f.g),
    .res_o (res_g)
  );

  sobl_lane u_lane_b (
    .clk_i (clk_i),
    .en_i  (en[NumStages-1:FrontStages]),
    .ctl_i (ctl),
    .src_i (src_f.b),
    .dst_i (dst_f.b),
    .res_o (res_b)
  );

  // alpha result is known after the front end, then just travels along
  logic [7:0] alpha_new;
  logic [7:0] alpha_q [LaneStages];

  always_comb begin
    case (ctl.mode)
      MODE_PASS: alpha_new = dst_f.a;
      MODE_COPY: alpha_new = ctl.sa;
      default:   alpha_new = 8'(9'(ctl.da2) + 9'(ctl.sa));
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en[FrontStages]) begin
      alpha_q[0] <= alpha_new;
    end
    for (int k = 1; k < LaneStages; k++) begin
      if (en[FrontStages+k]) begin
        alpha_q[k] <= alpha_q[k-1];
      end
    end
  end

  assign m_axis_tdata = {alpha_q[LaneStages-1], res_b, res_g, res_r};

`ifndef SYNTHESIS
  logic in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // a free output stage means the pipeline can always take a new pixel
  a_ready_when_tail_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q[NumStages-1] |-> s_axis_tready)
    else $error("input stalled with free output stage");

  // an accepted pixel lands in the first stage
  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> valid_q[0])
    else $error("accepted pixel not held in first stage");

  // occupancy changes only by transactions on the two streams
  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> ($countones(valid_q) ==
              $past($countones(valid_q)) + int'($past(in_acc)) - int'($past(out_acc))))
    else $error("pixel lost or duplicated in pipeline");
`endif

endmodule

`default_nettype wire

### sim/straight_alpha_over_blend_unit_tb.sv
module straight_alpha_over_blend_unit_tb
  import sobl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned PhaseItems    = 240;
  localparam int unsigned NumPhases     = 8;
  localparam int unsigned WatchdogLimit = 1000;
  localparam int unsigned LongHold      = 80;   // receiver hold-off, in cycles
  localparam int unsigned HoldAtOutput  = 400;  // output count that triggers it
  localparam int unsigned NumDirected   = 20;

  // directed stimulus; pixels written as 32'hAA_BB_GG_RR
  typedef struct packed {
    logic [8:0] opac;
    pix_t       src;
    pix_t       dst;
    logic       known;  // want is typed in, else the predictor decides
    pix_t       want;
  } stim_row_t;

  localparam stim_row_t DirectedRows [NumDirected] = '{
    // transparent source over an all-zero destination
    '{9'd256, 32'h00_00_00_00, 32'h00_00_00_00, 1'b1, 32'h00_00_00_00},
    // transparent source, destination at full scale
    '{9'd256, 32'h00_12_34_56, 32'hFF_FF_FF_FF, 1'b1, 32'hFF_FF_FF_FF},
    // opaque source copies through
    '{9'd256, 32'hFF_38_22_0C, 32'h80_32_64_C8, 1'b1, 32'hFF_38_22_0C},
    // empty destination copies the source
    '{9'd256, 32'h7F_20_40_80, 32'h00_03_02_01, 1'b1, 32'h7F_20_40_80},
    '{9'd256, 32'hFF_FF_FF_FF, 32'hFF_FF_FF_FF, 1'b1, 32'hFF_FF_FF_FF},
    // blends across the alpha range
    '{9'd256, 32'h80_00_00_FF, 32'hFF_FF_00_00, 1'b0, 32'h0},
    '{9'd256, 32'h01_FF_FF_FF, 32'hFF_00_00_00, 1'b0, 32'h0},
    '{9'd256, 32'hFE_00_00_00, 32'h01_FF_FF_FF, 1'b0, 32'h0},
    '{9'd256, 32'hFE_FF_FF_FF, 32'hFE_FF_FF_FF, 1'b0, 32'h0},
    '{9'd256, 32'h01_00_00_00, 32'h01_00_00_00, 1'b0, 32'h0},
    // opacity zero passes the destination
    '{9'd0,   32'hFF_03_02_01, 32'h06_07_08_09, 1'b1, 32'h06_07_08_09},
    '{9'd0,   32'hFF_FF_FF_FF, 32'h00_00_00_00, 1'b1, 32'h00_00_00_00},
    // smallest opacity scales an opaque source down to nothing
    '{9'd1,   32'hFF_FF_FF_FF, 32'h40_30_20_10, 1'b1, 32'h40_30_20_10},
    '{9'd255, 32'hFF_11_22_33, 32'hC8_44_55_66, 1'b0, 32'h0},
    // scaled source alpha 254 over an empty destination
    '{9'd255, 32'hFF_07_06_05, 32'h00_00_00_00, 1'b1, 32'hFE_07_06_05},
    '{9'd128, 32'h01_AA_BB_CC, 32'h55_01_02_03, 1'b1, 32'h55_01_02_03},
    '{9'd128, 32'hC8_10_80_F0, 32'h64_F0_80_10, 1'b0, 32'h0},
    // opacity above full rate behaves as full rate
    '{9'd511, 32'hFF_9A_BC_DE, 32'h77_11_22_33, 1'b1, 32'hFF_9A_BC_DE},
    '{9'd511, 32'h60_00_FF_80, 32'hA0_FF_00_80, 1'b0, 32'h0},
    '{9'd256, 32'h5A_A5_5A_A5, 32'hA5_5A_A5_5A, 1'b0, 32'h0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [8:0]  cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;

  pix_t        expected_pixels [$];
  logic [8:0]  opacity_model;
  int          fail_count;
  int          outputs_seen;
  int          send_calm;
  int          idle_cycles;

  always #1 clk_i = ~clk_i;

  straight_alpha_over_blend_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // rounded alpha-weighted average of two channel values
  function automatic logic [7:0] weigh_channel(input int unsigned d, input int unsigned da,
                                               input int unsigned s, input int unsigned sa,
                                               input int unsigned na);
    int unsigned sum;
    sum = (d * da + s * sa + na / 2) / na;
    return sum[7:0];
  endfunction

  // expected composite of one source pixel over one destination pixel
  function automatic pix_t over_pixel(input pix_t src, input pix_t dst, input logic [8:0] opac);
    int unsigned sa, da, da2, na;
    pix_t        res;
    res = dst;
    if (opac != 9'd0) begin
      sa = src.a;
      da = dst.a;
      if (opac < OpacityReset) sa = (sa * opac) >> 8;
      if (sa == 0) begin
        res = dst;
      end else if (sa == FullAlpha || da == 0) begin
        res   = src;
        res.a = sa[7:0];
      end else begin
        da2   = ((FullAlpha - sa) * da + HalfAlpha) / FullAlpha;
        na    = da2 + sa;
        res.r = weigh_channel(dst.r, da2, src.r, sa, na);
        res.g = weigh_channel(dst.g, da2, src.g, sa, na);
        res.b = weigh_channel(dst.b, da2, src.b, sa, na);
        res.a = na[7:0];
      end
    end
    return res;
  endfunction

  // idle length: mostly short, a few long, with calm stretches of none at all
  function automatic int gap_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 99) < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(11, 30);
  endfunction

  // byte with extra weight on both ends of the range
  function automatic logic [7:0] pick_byte();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return 8'h00;
    if (r == 1) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  // offer one pixel pair and log its expected composite on acceptance
  task automatic drive_pixel(input pix_t src, input pix_t dst, input pix_t want);
    int gap;
    gap = gap_len(send_calm);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {dst, src};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pixels.push_back(want);
    @(negedge clk_i);
  endtask

  // opacity is only written once the pipeline has drained
  task automatic set_opacity(input logic [8:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (NumStages + 2) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    opacity_model = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // stimulus
  initial begin
    logic [8:0] phase_opac [NumPhases];
    stim_row_t  row;
    pix_t       src, dst, want;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    opacity_model = OpacityReset;
    fail_count    = 0;
    send_calm     = 0;
    phase_opac = '{OpacityReset, 9'd0, 9'd1, 9'd255, 9'd128, 9'd511,
                   9'($urandom_range(2, 254)), 9'($urandom_range(257, 510))};
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < NumDirected; i++) begin
      row = DirectedRows[i];
      if (row.opac != opacity_model) set_opacity(row.opac);
      want = row.known ? row.want : over_pixel(row.src, row.dst, opacity_model);
      drive_pixel(row.src, row.dst, want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      set_opacity(phase_opac[ph]);
      for (int n = 0; n < PhaseItems; n++) begin
        src = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        dst = {pick_byte(), pick_byte(), pick_byte(), pick_byte()};
        drive_pixel(src, dst, over_pixel(src, dst, opacity_model));
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (NumStages + 4) @(posedge clk_i);
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // receiver: random stalls, plus one long hold-off so the pipeline backs up
  initial begin
    int stall_left;
    int calm;
    bit held;
    stall_left    = 0;
    calm          = 0;
    held          = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (!held && outputs_seen >= HoldAtOutput) begin
        held       = 1'b1;
        stall_left = LongHold;
      end
      if (stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready <= 1'b1;
        stall_left = gap_len(calm);
      end
    end
  end

  // compare every output transaction with the oldest expected composite
  initial outputs_seen = 0;

  always @(posedge clk_i) begin
    pix_t  got;
    pix_t  want;
    string field_name [4];
    field_name = '{"red", "green", "blue", "alpha"};
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      outputs_seen++;
      if (expected_pixels.size() == 0) begin
        $display("%0t unexpected output: expected none, got %h", $time, got);
        fail_count++;
      end else begin
        want = expected_pixels.pop_front();
        for (int k = 0; k < 4; k++) begin
          if (got[8*k +: 8] !== want[8*k +: 8]) begin
            $display("%0t mismatch out_%s: expected %0d, got %0d", $time, field_name[k],
                     want[8*k +: 8], got[8*k +: 8]);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog: too many cycles without any transaction ends the run
  initial idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
